// File: sv/jts_pkg.sv
// jts_pkg: shared types and constants for the JSON token scanner.
// Used by the scanner core, the result queue, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jts_pkg;

	// token kinds as they appear on the result channel
	typedef enum logic [2:0] {
		KIND_NULL     = 3'd0,
		KIND_TRUE     = 3'd1,
		KIND_FALSE    = 3'd2,
		KIND_BAD      = 3'd3,
		KIND_NUM_END  = 3'd4,
		KIND_NUM_CHAR = 3'd5,
		KIND_CHAR     = 3'd6,
		KIND_EOF      = 3'd7
	} kind_t;

	// scanner mode, one-hot
	typedef enum logic [2:0] {
		MODE_IDLE   = 3'b001,
		MODE_IDENT  = 3'b010,
		MODE_NUMBER = 3'b100
	} mode_t;

	// keyword flag positions: bit0 null, bit1 true, bit2 false
	localparam int KW_NULL  = 0;
	localparam int KW_TRUE  = 1;
	localparam int KW_FALSE = 2;

	localparam logic [2:0] LEN_NULL  = 3'd4;
	localparam logic [2:0] LEN_TRUE  = 3'd4;
	localparam logic [2:0] LEN_FALSE = 3'd5;
	localparam logic [2:0] LEN_MAX   = 3'd7;

	// result queue
	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef struct packed {
		kind_t      kind;
		logic [7:0] char_value;
		logic       last_of_run;
	} tok_t;

	// what one input beat produces: 0..2 tokens
	typedef struct packed {
		logic [1:0] cnt;
		tok_t       t0;
		tok_t       t1;
	} scan_res_t;

	// which keywords carry character c at position pos
	function automatic logic [2:0] kw_hit(logic [2:0] pos, logic [7:0] c);
		logic [2:0] h;
		h = 3'b000;
		case (pos)
			3'd0: h = {c == "f", c == "t", c == "n"};
			3'd1: h = {c == "a", c == "r", c == "u"};
			3'd2: h = {c == "l", c == "u", c == "l"};
			3'd3: h = {c == "s", c == "e", c == "l"};
			3'd4: h = {c == "e", 1'b0, 1'b0};
			default: h = 3'b000;
		endcase
		return h;
	endfunction

endpackage

`default_nettype wire

// File: sv/jts_if.sv
// jts_in_if / jts_out_if: valid/ready channels of the JSON token scanner.
// Input carries one character beat, output one token beat. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface jts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_req;
	logic       is_end;

	modport source(output valid, byte_req, is_end, input ready);
	modport sink(input valid, byte_req, is_end, output ready);
endinterface

interface jts_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] char_value;
	logic       last_of_run;

	modport source(output valid, kind, char_value, last_of_run, input ready);
	modport sink(input valid, kind, char_value, last_of_run, output ready);
endinterface

`default_nettype wire

// File: sv/jts_scan.sv
// jts_scan: per-character classification and scanner state.
// Produces up to two tokens per accepted beat. Depends on jts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jts_scan
	import jts_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] byte_req,
	input  wire logic       is_end,
	output scan_res_t       res
);

	mode_t      mode_q, mode_d;
	logic [2:0] km_q, km_d;
	logic [2:0] len_q, len_d;
	logic       done_q, done_d;

	logic  is_ws, is_alpha, is_digit, is_num, is_word;
	mode_t st_mode;
	logic  st_emit;
	kind_t st_kind;
	kind_t id_kind;
	tok_t  st_tok;

	always_comb begin
		is_ws    = byte_req inside {8'h20, [8'h09:8'h0D]};
		is_alpha = byte_req inside {["a":"z"], ["A":"Z"]};
		is_digit = byte_req inside {["0":"9"]};
		is_num   = is_digit || (byte_req == ".");
		is_word  = is_alpha || is_digit || (byte_req == "_");
	end

	// start of a new token at byte_req
	always_comb begin
		st_emit = 1'b0;
		st_kind = KIND_CHAR;
		if (is_ws) begin
			st_mode = MODE_IDLE;
		end else if (is_alpha) begin
			st_mode = MODE_IDENT;
		end else if (is_num) begin
			st_mode = MODE_NUMBER;
			st_emit = 1'b1;
			st_kind = KIND_NUM_CHAR;
		end else begin
			st_mode = MODE_IDLE;
			st_emit = 1'b1;
		end
		st_tok = '{kind: st_kind, char_value: byte_req, last_of_run: 1'b0};
	end

	always_comb begin
		if (km_q[KW_NULL] && len_q == LEN_NULL) begin
			id_kind = KIND_NULL;
		end else if (km_q[KW_TRUE] && len_q == LEN_TRUE) begin
			id_kind = KIND_TRUE;
		end else if (km_q[KW_FALSE] && len_q == LEN_FALSE) begin
			id_kind = KIND_FALSE;
		end else begin
			id_kind = KIND_BAD;
		end
	end

	always_comb begin
		res    = '0;
		mode_d = mode_q;
		km_d   = km_q;
		len_d  = len_q;
		done_d = done_q;
		if (done_q) begin
			res.cnt     = 2'd1;
			res.t0.kind = KIND_EOF;
		end else if (is_end) begin
			mode_d = MODE_IDLE;
			km_d   = '0;
			len_d  = '0;
			done_d = 1'b1;
			case (mode_q)
				MODE_IDENT: begin
					res.cnt     = 2'd2;
					res.t0.kind = id_kind;
					res.t1.kind = KIND_EOF;
				end
				MODE_NUMBER: begin
					res.cnt     = 2'd2;
					res.t0.kind = KIND_NUM_END;
					res.t1.kind = KIND_EOF;
				end
				default: begin
					res.cnt     = 2'd1;
					res.t0.kind = KIND_EOF;
				end
			endcase
		end else begin
			case (mode_q)
				MODE_IDENT: begin
					if (is_word) begin
						km_d = km_q & kw_hit(len_q, byte_req);
						if (len_q != LEN_MAX) begin
							len_d = len_q + 3'd1;
						end
					end else begin
						// identifier closes, byte starts the next token
						res.t0.kind = id_kind;
						res.t1      = st_tok;
						res.cnt     = st_emit ? 2'd2 : 2'd1;
						mode_d      = st_mode;
						km_d        = is_alpha ? kw_hit(3'd0, byte_req) : 3'b000;
						len_d       = is_alpha ? 3'd1 : 3'd0;
					end
				end
				MODE_NUMBER: begin
					if (is_num) begin
						res.cnt = 2'd1;
						res.t0  = st_tok;
					end else begin
						res.t0.kind = KIND_NUM_END;
						res.t1      = st_tok;
						res.cnt     = st_emit ? 2'd2 : 2'd1;
						mode_d      = st_mode;
						if (is_alpha) begin
							km_d  = kw_hit(3'd0, byte_req);
							len_d = 3'd1;
						end
					end
				end
				default: begin
					res.t0  = st_tok;
					res.cnt = st_emit ? 2'd1 : 2'd0;
					mode_d  = st_mode;
					if (is_alpha) begin
						km_d  = kw_hit(3'd0, byte_req);
						len_d = 3'd1;
					end
				end
			endcase
		end
		res.t0.last_of_run = (res.cnt == 2'd1);
		res.t1.last_of_run = (res.cnt == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			km_q   <= '0;
			len_q  <= '0;
			done_q <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_d;
			km_q   <= km_d;
			len_q  <= len_d;
			done_q <= done_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/jts_fifo.sv
// jts_fifo: small token queue; takes up to two tokens a cycle, gives one.
// Decouples the scanner from output stalls. Depends on jts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jts_fifo
	import jts_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire scan_res_t push,
	output logic           room,
	output logic           head_valid,
	output tok_t           head,
	input  wire logic      pop
);

	tok_t             mem_q [QDEPTH];
	logic [QPW-1:0]   wp_q, rp_q;
	logic [QCW-1:0]   cnt_q;
	logic [QPW-1:0]   wp1;
	logic             do_pop;

	assign room       = (cnt_q <= QCW'(QDEPTH - 2));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rp_q];
	assign do_pop     = pop && head_valid;
	assign wp1        = wp_q + QPW'(1);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wp_q] <= push.t0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wp1] <= push.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + QPW'(push.cnt);
			rp_q  <= rp_q + QPW'(do_pop);
			cnt_q <= cnt_q + QCW'(push.cnt) - QCW'(do_pop);
		end
	end

endmodule

`default_nettype wire

// File: sv/json_token_scanner.sv
// json_token_scanner: streaming JSON-style token scanner, top level.
// Instantiates jts_scan and jts_fifo; uses jts_pkg and jts_if.
//
//   channel   dir  beat                          handshake
//   char_in   in   byte_req[7:0], is_end         valid/ready
//   tok_out   out  kind[2:0], char_value[7:0],   valid/ready
//                  last_of_run
//
// One beat per cycle while ready; each makes 0, 1 or 2 tokens, sent one per cycle.
// Scanning is combinational logic from the state registers into a 4-entry token queue.
// char_in.ready drops when the queue cannot take two more tokens.
// Sustained rate is set by tok_out: one token per cycle.
// Reset (arst_n low) empties the queue and returns the scanner to idle.
`timescale 1ns / 1ps
`default_nettype none

module json_token_scanner
	import jts_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	jts_in_if.sink    char_in,
	jts_out_if.source tok_out
);

	scan_res_t scan_res, push;
	logic      room, fire, head_valid;
	tok_t      head;

	assign char_in.ready = room;
	assign fire          = char_in.valid && room;

	jts_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.byte_req (char_in.byte_req),
		.is_end   (char_in.is_end),
		.res      (scan_res)
	);

	always_comb begin
		push = scan_res;
		if (!fire) begin
			push.cnt = 2'd0;
		end
	end

	jts_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head_valid (head_valid),
		.head       (head),
		.pop        (tok_out.ready)
	);

	assign tok_out.valid       = head_valid;
	assign tok_out.kind        = head.kind;
	assign tok_out.char_value  = head.char_value;
	assign tok_out.last_of_run = head.last_of_run;

endmodule

`default_nettype wire

// File: sv/jts_checker.sv
// jts_checker: port-level assertions for json_token_scanner, bound to the top.
// Depends on jts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jts_checker
	import jts_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] out_kind,
	input wire logic [7:0] out_char,
	input wire logic       out_last
);

	// EOF is always the last token of its beat and carries no character
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_EOF |-> out_last && out_char == 8'h00)
		else $error("EOF token malformed");

	// keyword/number-end tokens carry no character
	a_nochar: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_NULL || out_kind == KIND_TRUE ||
		out_kind == KIND_FALSE || out_kind == KIND_BAD || out_kind == KIND_NUM_END)
		|-> out_char == 8'h00)
		else $error("character on a non-character token");

	// input can only be held off while tokens are waiting
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// stalled token beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
		$stable(out_char) && $stable(out_last))
		else $error("token beat changed while stalled");

endmodule

bind json_token_scanner jts_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (char_in.ready),
	.out_valid (tok_out.valid),
	.out_ready (tok_out.ready),
	.out_kind  (tok_out.kind),
	.out_char  (tok_out.char_value),
	.out_last  (tok_out.last_of_run)
);

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking bench for json_token_scanner.
// Streams directed and random character beats, predicts every token and checks them in order.
// Depends on jts_pkg, jts_in_if / jts_out_if and the json_token_scanner RTL.
`timescale 1ns / 1ps

module tb_top;
	import jts_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_BEATS = 1500;
	localparam int STEADY_BEATS = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int IDLE_PCT     = 37;

	localparam logic [31:0] TXT_NULL  = "null";
	localparam logic [31:0] TXT_TRUE  = "true";
	localparam logic [39:0] TXT_FALSE = "false";

	logic clk;
	logic arst_n;

	jts_in_if  char_in();
	jts_out_if tok_out();

	json_token_scanner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.char_in(char_in),
		.tok_out(tok_out)
	);

	// scanner shadow state
	mode_t      scan_mode;
	logic [2:0] kw_alive;
	logic [2:0] id_len;
	logic       input_closed;

	tok_t beat_toks[2];
	int   beat_n;
	tok_t pending_tokens[$];

	bit steady;
	int errors;
	int beats_sent;
	int tokens_checked;
	int cycle_count;
	int kind_count[8];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------- prediction ----------------

	function automatic bit is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic int kw_len(input int k);
		return (k == KW_FALSE) ? 5 : 4;
	endfunction

	function automatic logic [7:0] kw_char(input int k, input int pos);
		case (k)
			KW_NULL:  return TXT_NULL[31 - 8 * pos -: 8];
			KW_TRUE:  return TXT_TRUE[31 - 8 * pos -: 8];
			default:  return TXT_FALSE[39 - 8 * pos -: 8];
		endcase
	endfunction

	// keywords that carry c at position pos
	function automatic logic [2:0] kw_fits(input int pos, input logic [7:0] c);
		logic [2:0] m;
		m = 3'b000;
		for (int k = 0; k < 3; k++) begin
			if (pos < kw_len(k) && kw_char(k, pos) == c)
				m[k] = 1'b1;
		end
		return m;
	endfunction

	function automatic kind_t ident_class();
		if (kw_alive[KW_NULL] && id_len == LEN_NULL)
			return KIND_NULL;
		if (kw_alive[KW_TRUE] && id_len == LEN_TRUE)
			return KIND_TRUE;
		if (kw_alive[KW_FALSE] && id_len == LEN_FALSE)
			return KIND_FALSE;
		return KIND_BAD;
	endfunction

	task automatic emit_tok(input kind_t k, input logic [7:0] ch);
		tok_t t;
		t.kind        = k;
		t.char_value  = ch;
		t.last_of_run = 1'b0;
		beat_toks[beat_n] = t;
		beat_n++;
	endtask

	task automatic open_token(input logic [7:0] c);
		if (is_space(c)) begin
			scan_mode = MODE_IDLE;
		end else if (is_letter(c)) begin
			scan_mode = MODE_IDENT;
			kw_alive  = kw_fits(0, c);
			id_len    = 3'd1;
		end else if (is_digit(c) || c == ".") begin
			scan_mode = MODE_NUMBER;
			emit_tok(KIND_NUM_CHAR, c);
		end else begin
			scan_mode = MODE_IDLE;
			emit_tok(KIND_CHAR, c);
		end
	endtask

	task automatic tokenize_beat(input logic [7:0] c, input logic fin);
		tok_t t;
		beat_n = 0;
		if (input_closed) begin
			emit_tok(KIND_EOF, 8'h00);
		end else if (fin) begin
			if (scan_mode == MODE_IDENT)
				emit_tok(ident_class(), 8'h00);
			else if (scan_mode == MODE_NUMBER)
				emit_tok(KIND_NUM_END, 8'h00);
			emit_tok(KIND_EOF, 8'h00);
			scan_mode    = MODE_IDLE;
			kw_alive     = 3'b000;
			id_len       = 3'd0;
			input_closed = 1'b1;
		end else if (scan_mode == MODE_IDENT) begin
			if (is_letter(c) || is_digit(c) || c == "_") begin
				kw_alive = kw_alive & kw_fits(int'(id_len), c);
				if (id_len < LEN_MAX)
					id_len = id_len + 3'd1;
			end else begin
				emit_tok(ident_class(), 8'h00);
				kw_alive = 3'b000;
				id_len   = 3'd0;
				open_token(c);
			end
		end else if (scan_mode == MODE_NUMBER) begin
			if (is_digit(c) || c == ".") begin
				emit_tok(KIND_NUM_CHAR, c);
			end else begin
				emit_tok(KIND_NUM_END, 8'h00);
				open_token(c);
			end
		end else begin
			open_token(c);
		end
		for (int i = 0; i < beat_n; i++) begin
			t = beat_toks[i];
			t.last_of_run = (i == beat_n - 1);
			pending_tokens.push_back(t);
		end
	endtask

	// ---------------- checking ----------------

	task automatic check_token(input logic [2:0] k, input logic [7:0] ch, input logic last);
		tok_t want;
		if (pending_tokens.size() == 0) begin
			$display("%0t: unexpected token: kind %0d char %02h last %0b", $time, k, ch, last);
			errors++;
		end else begin
			want = pending_tokens.pop_front();
			tokens_checked++;
			kind_count[k]++;
			if (k !== want.kind) begin
				$display("%0t: kind mismatch: expected %0d, actual %0d", $time, want.kind, k);
				errors++;
			end
			if (ch !== want.char_value) begin
				$display("%0t: char_value mismatch: expected %02h, actual %02h",
					$time, want.char_value, ch);
				errors++;
			end
			if (last !== want.last_of_run) begin
				$display("%0t: last_of_run mismatch: expected %0b, actual %0b",
					$time, want.last_of_run, last);
				errors++;
			end
		end
	endtask

	// inputs settle at the falling edge, so these reads see pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (char_in.valid && char_in.ready)
				tokenize_beat(char_in.byte_req, char_in.is_end);
			if (tok_out.valid && tok_out.ready)
				check_token(tok_out.kind, tok_out.char_value, tok_out.last_of_run);
		end
	end

	// ---------------- driving ----------------

	always @(negedge clk) begin
		tok_out.ready = steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// entered and left just after a falling edge; valid is left high on return until the next beat or an idle gap
	task automatic send_beat(input logic [7:0] b, input logic fin);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			char_in.valid = 1'b0;
			@(negedge clk);
		end
		char_in.valid    = 1'b1;
		char_in.byte_req = b;
		char_in.is_end   = fin;
		do
			@(posedge clk);
		while (!char_in.ready);
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_beat(s[i], 1'b0);
	endtask

	function automatic logic [7:0] rand_ident_char();
		int r;
		r = $urandom_range(62);
		if (r < 26)
			return 8'("a" + r);
		if (r < 52)
			return 8'("A" + r - 26);
		if (r < 62)
			return 8'("0" + r - 52);
		return "_";
	endfunction

	function automatic logic [7:0] rand_number_char();
		return ($urandom_range(5) == 0) ? 8'(".") : 8'("0" + $urandom_range(9));
	endfunction

	function automatic logic [7:0] rand_separator();
		string punct;
		punct = "{}[]:,\"-+";
		if ($urandom_range(1))
			return ($urandom_range(3) == 0) ? 8'h20 : 8'($urandom_range(8'h09, 8'h0D));
		return punct[$urandom_range(punct.len() - 1)];
	endfunction

	// exact or slightly broken keyword
	task automatic send_keyword(input bit exact);
		int k;
		int n;
		int pos;
		int how;
		logic [7:0] c;
		k   = $urandom_range(2);
		n   = kw_len(k);
		how = exact ? -1 : $urandom_range(3);
		pos = $urandom_range(n - 1);
		if (how == 0)
			n--;
		for (int i = 0; i < n; i++) begin
			c = kw_char(k, i);
			if (i == pos && how == 2)
				c = 8'("a" + $urandom_range(25));
			else if (i == pos && how == 3)
				c = c ^ 8'h20;
			send_beat(c, 1'b0);
		end
		if (how == 1)
			send_beat(rand_ident_char(), 1'b0);
	endtask

	task automatic send_random_token();
		int n;
		case ($urandom_range(9))
			0, 1: send_keyword(1'b1);
			2:    send_keyword(1'b0);
			3: begin
				n = $urandom_range(1, 9);
				send_beat($urandom_range(1) ? 8'("a" + $urandom_range(25))
					: 8'("A" + $urandom_range(25)), 1'b0);
				for (int i = 1; i < n; i++)
					send_beat(rand_ident_char(), 1'b0);
			end
			4, 5: begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					send_beat(rand_number_char(), 1'b0);
			end
			6: send_beat(rand_separator(), 1'b0);
			7: begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++)
					send_beat(8'($urandom_range(8'h09, 8'h0D)), 1'b0);
			end
			8: send_beat(8'($urandom_range(255)), 1'b0);
			default: begin
				case ($urandom_range(2))
					0: send_beat(8'h00, 1'b0);
					1: send_beat(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
					default: send_beat(8'($urandom_range(8'h01, 8'h1F)), 1'b0);
				endcase
			end
		endcase
		if ($urandom_range(9) < 6)
			send_beat(rand_separator(), 1'b0);
	endtask

	// ---------------- tests ----------------

	task automatic test_keywords();
		send_text("null true\tfalse");
		send_beat(8'hFF, 1'b0);           // closes false and is a char token itself
	endtask

	task automatic test_token_boundaries();
		send_text("ab.9,");               // ident cut by number, number cut by char token
		send_beat(8'h0C, 1'b0);
		send_beat(8'h00, 1'b0);
	endtask

	task automatic test_long_ident();
		send_text("nullnull");            // length saturates, no keyword
		send_beat(8'h0D, 1'b0);
	endtask

	task automatic test_random_stream();
		int stop_at;
		stop_at = beats_sent + RANDOM_BEATS;
		steady  = 1'b1;
		while (beats_sent < stop_at) begin
			if (beats_sent >= stop_at - RANDOM_BEATS + STEADY_BEATS)
				steady = 1'b0;
			send_random_token();
		end
	endtask

	// end of input can only happen once per run, so it comes last
	task automatic test_end_of_input();
		int n;
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++)
			send_beat($urandom_range(1) ? rand_ident_char() : rand_number_char(), 1'b0);
		send_beat(8'($urandom_range(255)), 1'b1);
		for (int i = 0; i < 8; i++)
			send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout, %0d tokens still expected", $time, pending_tokens.size());
		$display("** json_token_scanner: FAILED **");
		$finish;
	end

	initial begin
		int directed_beats;
		scan_mode        = MODE_IDLE;
		kw_alive         = 3'b000;
		id_len           = 3'd0;
		input_closed     = 1'b0;
		steady           = 1'b0;
		char_in.valid    = 1'b0;
		char_in.byte_req = 8'h00;
		char_in.is_end   = 1'b0;
		tok_out.ready    = 1'b0;
		arst_n           = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_keywords();
		test_token_boundaries();
		test_long_ident();
		directed_beats = beats_sent;
		test_random_stream();
		test_end_of_input();

		char_in.valid = 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d character beats (%0d directed), %0d tokens checked",
			beats_sent, directed_beats, tokens_checked);
		$display("kinds: null %0d true %0d false %0d bad %0d numend %0d numchar %0d char %0d eof %0d",
			kind_count[0], kind_count[1], kind_count[2], kind_count[3],
			kind_count[4], kind_count[5], kind_count[6], kind_count[7]);
		if (errors == 0) begin
			$display("** json_token_scanner: PASSED **");
		end else begin
			$display("%0d mismatches", errors);
			$display("** json_token_scanner: FAILED **");
		end
		$finish;
	end

endmodule
